FILE: design/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

   localparam int NumBusesDefault = 4;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_START1  = 5'd1,
      PH_HW1     = 5'd2,
      PH_LO1     = 5'd3,
      PH_REGHI   = 5'd4,
      PH_REGLO   = 5'd5,
      PH_DELAYF  = 5'd6,
      PH_START2  = 5'd7,
      PH_HW2     = 5'd8,
      PH_LO2     = 5'd9,
      PH_RESTART = 5'd10,
      PH_RD      = 5'd11,
      PH_DELAYB  = 5'd12,
      PH_RX      = 5'd13,
      PH_WAIT    = 5'd14,
      PH_DATA    = 5'd15,
      PH_STOPOK  = 5'd16,
      PH_STOPNAK = 5'd17
   } phase_type;

   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_WRITE = 3'd1;
   localparam logic [2:0] ACT_DREAD = 3'd2;
   localparam logic [2:0] ACT_RREAD = 3'd3;
   localparam logic [2:0] ACT_BYTE  = 3'd4;

   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_DREAD = 2'd2;
   localparam logic [1:0] OP_RREAD = 2'd3;

   localparam logic [2:0] REG_DEVADDR = 3'd0;
   localparam logic [2:0] REG_TENBIT  = 3'd1;
   localparam logic [2:0] REG_REG2    = 3'd2;
   localparam logic [2:0] REG_RETRY   = 3'd3;
   localparam logic [2:0] REG_DPLACE  = 3'd4;
   localparam logic [2:0] REG_DTICKS  = 3'd5;

   localparam logic [1:0] DLY_BEFORE = 2'd1;
   localparam logic [1:0] DLY_AFTER  = 2'd2;

endpackage
`default_nettype wire

FILE: design/i2c_master_transaction_engine.sv
`default_nettype none
// Each accepted word's result word is registered in the output register.
// Throughput: one word per cycle unless the output stalls; one state update per slot sets it.
// A new word is taken while the previous result waits, as long as the output register frees.
// Reset (synchronous, active high) returns the sequencer to idle, all lines high,
// configuration to its defaults (retry limit one) and the result channel empty.
module i2c_master_transaction_engine #(
   parameter int NUM_BUSES = i2cm_pkg::NumBusesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [2:0]  req_bus_index,
   input  wire logic [15:0] req_register_address,
   input  wire logic [7:0]  req_length,
   input  wire logic [7:0]  req_write_byte,
   input  wire logic [3:0]  req_sda_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_scl_levels,
   output logic [3:0]       rsp_sda_levels,
   output logic [3:0]       rsp_sda_listen,
   output logic             rsp_busy_res,
   output logic             rsp_byte_request,
   output logic             rsp_read_valid,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_last_byte,
   output logic             rsp_done_res,
   output logic             rsp_failed,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import i2cm_pkg::*;

   logic [15:0] dev_addr_ff;
   logic        ten_bit_ff, reg2_ff;
   logic [7:0]  retry_ff;
   logic [1:0]  dplace_ff;
   logic [15:0] dticks_ff;

   phase_type   phase_ff, phase_in;
   logic [1:0]  slot_ff, slot_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  bcnt_ff, bcnt_in;
   logic [7:0]  btot_ff, btot_in;
   logic [7:0]  att_ff, att_in;
   logic [15:0] dly_ff, dly_in;
   logic [2:0]  bus_ff, bus_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] rega_ff, rega_in;
   logic [3:0]  scl_ff, scl_in;
   logic [3:0]  sda_ff, sda_in;

   logic [3:0] o_listen;
   logic       o_rv, o_last, o_done, o_fail;
   logic [7:0] o_rdata;

   logic       step;
   logic [3:0] busbit, busbit_n;
   logic       sample;
   logic [7:0] hdr, lo;

   assign req_ready = !rsp_valid || rsp_ready;
   assign step = req_valid && req_ready;

   // Buses at or above the bus count, or beyond the four line bits, have no lines.
   always_comb begin
      busbit = '0;
      if (int'(bus_ff) < NUM_BUSES && bus_ff < 3'd4) begin
         busbit[bus_ff[1:0]] = 1'b1;
      end
   end
   assign busbit_n = busbit;
   assign sample = (bus_ff < 3'd4) ? req_sda_in[bus_ff[1:0]] : 1'b1;
   assign hdr = dev_addr_ff[15:8] & 8'hFE;
   assign lo = dev_addr_ff[7:0];

   function automatic logic [7:0] addr_byte(input phase_type ph, input logic tb,
                                            input logic [7:0] h, input logic [7:0] l,
                                            input logic [15:0] ra);
      unique case (ph)
         PH_HW1:           addr_byte = tb ? h : (l & 8'hFE);
         PH_HW2:           addr_byte = h;
         PH_LO1, PH_LO2:   addr_byte = l;
         PH_REGHI:         addr_byte = ra[15:8];
         PH_REGLO:         addr_byte = ra[7:0];
         PH_RD:            addr_byte = (tb ? h : (l & 8'hFE)) | 8'h01;
         default:          addr_byte = 8'h00;
      endcase
   endfunction

   always_comb begin
      phase_type nx;
      logic      go;
      logic      nak;
      logic [7:0] bc;
      phase_in = phase_ff; slot_in = slot_ff; bit_in = bit_ff; shift_in = shift_ff;
      bcnt_in = bcnt_ff; btot_in = btot_ff; att_in = att_ff; dly_in = dly_ff;
      bus_in = bus_ff; op_in = op_ff; rega_in = rega_ff; scl_in = scl_ff; sda_in = sda_ff;
      o_listen = '0; o_rv = 1'b0; o_last = 1'b0; o_done = 1'b0; o_fail = 1'b0;
      o_rdata = '0;
      nx = PH_IDLE; go = 1'b0; nak = 1'b0;
      bc = bcnt_ff;
      if (phase_ff == PH_IDLE) begin
         if (req_action == ACT_WRITE || req_action == ACT_DREAD || req_action == ACT_RREAD) begin
            if (int'(req_bus_index) >= NUM_BUSES || retry_ff == 8'd0) begin
               o_fail = 1'b1;
            end else begin
               bus_in = req_bus_index;
               op_in = req_action[1:0];
               rega_in = req_register_address;
               btot_in = req_length;
               att_in = retry_ff;
               bcnt_in = '0;
               nx = PH_START1; go = 1'b1;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_START1, PH_START2, PH_RESTART: begin
               if (slot_ff == 2'd0) begin
                  sda_in = sda_ff | busbit; scl_in = scl_ff | busbit; slot_in = 2'd1;
               end else if (slot_ff == 2'd1) begin
                  sda_in = sda_ff & ~busbit_n; slot_in = 2'd2;
               end else begin
                  scl_in = scl_ff & ~busbit_n;
                  go = 1'b1;
                  priority case (phase_ff)
                     PH_START1: nx = (op_ff == OP_DREAD && !ten_bit_ff) ? PH_RD : PH_HW1;
                     PH_START2: nx = ten_bit_ff ? PH_HW2 : PH_RD;
                     default:   nx = PH_RD;
                  endcase
               end
            end
            PH_HW1, PH_LO1, PH_REGHI, PH_REGLO, PH_HW2, PH_LO2, PH_RD, PH_DATA: begin
               if (!bit_ff[3]) begin
                  if (slot_ff == 2'd0) begin
                     sda_in = shift_ff[3'd7 - bit_ff[2:0]] ? (sda_ff | busbit)
                                                           : (sda_ff & ~busbit_n);
                     slot_in = 2'd1;
                  end else if (slot_ff == 2'd1) begin
                     scl_in = scl_ff | busbit; slot_in = 2'd2;
                  end else begin
                     scl_in = scl_ff & ~busbit_n; slot_in = 2'd0; bit_in = bit_ff + 4'd1;
                  end
               end else begin
                  o_listen = busbit;
                  if (slot_ff == 2'd0) begin
                     sda_in = sda_ff | busbit; scl_in = scl_ff | busbit;
                     shift_in = {7'd0, sample}; slot_in = 2'd1;
                  end else begin
                     scl_in = scl_ff & ~busbit_n;
                     go = 1'b1;
                     if (shift_ff[0]) begin
                        nx = PH_STOPNAK;
                     end else begin
                        priority case (phase_ff)
                           PH_HW1, PH_LO1: begin
                              if (phase_ff == PH_HW1 && ten_bit_ff) nx = PH_LO1;
                              else if (phase_ff == PH_LO1 && op_ff == OP_DREAD) nx = PH_RESTART;
                              else if (op_ff == OP_WRITE) begin
                                 bc = 8'd0;
                                 nx = (8'd0 < btot_ff) ? PH_WAIT : PH_STOPOK;
                              end else if (op_ff == OP_DREAD) nx = PH_RESTART;
                              else nx = reg2_ff ? PH_REGHI : PH_REGLO;
                           end
                           PH_REGHI: nx = PH_REGLO;
                           PH_REGLO: nx = (dplace_ff == DLY_BEFORE && dticks_ff != 16'd0)
                                          ? PH_DELAYF : PH_START2;
                           PH_HW2:   nx = PH_LO2;
                           PH_LO2:   nx = PH_RESTART;
                           PH_RD: begin
                              bc = 8'd0;
                              if (op_ff == OP_RREAD && dplace_ff == DLY_AFTER &&
                                  dticks_ff != 16'd0) nx = PH_DELAYB;
                              else nx = (8'd0 < btot_ff) ? PH_RX : PH_STOPOK;
                           end
                           default: begin
                              bc = bcnt_ff + 8'd1;
                              nx = (bc < btot_ff) ? PH_WAIT : PH_STOPOK;
                           end
                        endcase
                     end
                  end
               end
            end
            PH_RX: begin
               if (!bit_ff[3]) begin
                  o_listen = busbit;
                  if (slot_ff == 2'd0) begin
                     scl_in = scl_ff | busbit; shift_in = {shift_ff[6:0], sample};
                     slot_in = 2'd1;
                  end else begin
                     scl_in = scl_ff & ~busbit_n; slot_in = 2'd0; bit_in = bit_ff + 4'd1;
                  end
               end else begin
                  nak = !((9'(bcnt_ff) + 9'd1) < 9'(btot_ff));
                  if (slot_ff == 2'd0) begin
                     sda_in = nak ? (sda_ff | busbit) : (sda_ff & ~busbit_n); slot_in = 2'd1;
                  end else if (slot_ff == 2'd1) begin
                     scl_in = scl_ff | busbit; slot_in = 2'd2;
                  end else begin
                     scl_in = scl_ff & ~busbit_n;
                     o_rv = 1'b1; o_rdata = shift_ff; o_last = nak;
                     bc = bcnt_ff + 8'd1;
                     go = 1'b1; nx = (bc < btot_ff) ? PH_RX : PH_STOPOK;
                  end
               end
            end
            PH_DELAYF, PH_DELAYB: begin
               if (dly_ff > 16'd1) begin
                  dly_in = dly_ff - 16'd1;
               end else begin
                  dly_in = '0; go = 1'b1;
                  if (phase_ff == PH_DELAYF) nx = PH_START2;
                  else nx = (bcnt_ff < btot_ff) ? PH_RX : PH_STOPOK;
               end
            end
            PH_WAIT: begin
               if (req_action == ACT_BYTE) begin
                  go = 1'b1; nx = PH_DATA;
               end
            end
            PH_STOPOK, PH_STOPNAK: begin
               if (slot_ff == 2'd0) begin
                  sda_in = sda_ff & ~busbit_n; scl_in = scl_ff | busbit; slot_in = 2'd1;
               end else begin
                  sda_in = sda_ff | busbit; go = 1'b1;
                  if (phase_ff == PH_STOPOK) begin
                     o_done = 1'b1; nx = PH_IDLE;
                  end else begin
                     logic [7:0] a;
                     a = (att_ff > 8'd0) ? att_ff - 8'd1 : att_ff;
                     att_in = a;
                     if (a == 8'd0) begin
                        o_fail = 1'b1; nx = PH_IDLE;
                     end else begin
                        bc = 8'd0; nx = PH_START1;
                     end
                  end
               end
            end
            default: begin
               go = 1'b1; nx = PH_IDLE;
            end
         endcase
      end
      bcnt_in = (phase_ff == PH_IDLE) ? bcnt_in : bc;
      if (go) begin
         phase_in = nx; slot_in = '0; bit_in = '0;
         shift_in = addr_byte(nx, ten_bit_ff, hdr, lo, rega_in);
         if (phase_ff == PH_WAIT) shift_in = req_write_byte;
         if (nx == PH_DELAYF || nx == PH_DELAYB) dly_in = dticks_ff;
         if (nx == PH_RX) sda_in = sda_in | busbit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= '0; ten_bit_ff <= 1'b0; reg2_ff <= 1'b0;
         retry_ff <= 8'd1; dplace_ff <= '0; dticks_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DEVADDR: dev_addr_ff <= csr_data;
            REG_TENBIT:  ten_bit_ff <= csr_data[0];
            REG_REG2:    reg2_ff <= csr_data[0];
            REG_RETRY:   retry_ff <= csr_data[7:0];
            REG_DPLACE:  dplace_ff <= csr_data[1:0];
            REG_DTICKS:  dticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; slot_ff <= '0; bit_ff <= '0; shift_ff <= '0;
         bcnt_ff <= '0; btot_ff <= '0; att_ff <= '0; dly_ff <= '0;
         bus_ff <= '0; op_ff <= '0; rega_ff <= '0; scl_ff <= '1; sda_ff <= '1;
         rsp_valid <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in; slot_ff <= slot_in; bit_ff <= bit_in; shift_ff <= shift_in;
            bcnt_ff <= bcnt_in; btot_ff <= btot_in; att_ff <= att_in; dly_ff <= dly_in;
            bus_ff <= bus_in; op_ff <= op_in; rega_ff <= rega_in;
            scl_ff <= scl_in; sda_ff <= sda_in;
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_scl_levels <= scl_in;
         rsp_sda_levels <= sda_in;
         rsp_sda_listen <= o_listen;
         rsp_busy_res <= phase_in != PH_IDLE;
         rsp_byte_request <= phase_in == PH_WAIT;
         rsp_read_valid <= o_rv;
         rsp_read_data <= o_rdata;
         rsp_last_byte <= o_last;
         rsp_done_res <= o_done;
         rsp_failed <= o_fail;
      end
   end

endmodule
`default_nettype wire

FILE: design/i2cm_checker.sv
`default_nettype none
module i2cm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_sda_listen,
   input wire logic       rsp_busy_res,
   input wire logic       rsp_byte_request,
   input wire logic       rsp_read_valid,
   input wire logic       rsp_done_res,
   input wire logic       rsp_failed
);

   // A word accepted always yields a result word on the next cycle.
   a_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid) else $error("missing result word");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("input taken while output stalled");

   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_failed) else $error("bad completion");

   a_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_request |-> rsp_busy_res && !rsp_read_valid)
      else $error("byte wait outside a transaction");

   a_listen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_sda_listen)) else $error("listening on several buses");

endmodule

bind i2c_master_transaction_engine i2cm_checker u_i2cm_checker (.*);
`default_nettype wire
